// ===== src/secc_pkg.sv =====
package secc_pkg;

   // default sizes
   localparam int NUM_NODES_DEF      = 65536;
   localparam int MAX_THRESHOLDS_DEF = 8;

   // field widths
   localparam int NODE_W  = 16;
   localparam int COMM_W  = 17;
   localparam int VOL_W   = 32;
   localparam int QLANE_W = 3;
   localparam int MOVE_W  = 2;
   localparam int CSR_IDX_W = 2;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VMAX_START      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VMAX_END        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MERGE_CONDITION = 2'd2;

   // request function codes
   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // move kinds
   localparam logic [MOVE_W-1:0] MOVE_NONE = 2'd0;
   localparam logic [MOVE_W-1:0] MOVE_SRC  = 2'd1;
   localparam logic [MOVE_W-1:0] MOVE_TGT  = 2'd2;

   localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};

   function automatic logic [VOL_W-1:0] sat_add(input logic [VOL_W-1:0] a,
                                                input logic [VOL_W-1:0] b);
      logic [VOL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VOL_W] ? VOL_MAX : s[VOL_W-1:0];
   endfunction

   function automatic logic [VOL_W-1:0] sat_sub(input logic [VOL_W-1:0] a,
                                                input logic [VOL_W-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

endpackage

// ===== src/streaming_edge_community_clustering.sv =====
// channel   direction  ports                                          handshake
// req       in         req_func req_source_node req_target_node       req_valid/req_ready
//                      req_query_lane
// rsp       out        rsp_lane rsp_source_community                  rsp_valid/rsp_ready
//                      rsp_target_community rsp_move_kind rsp_last
// csr       in         csr_index csr_wdata                            csr_we, no wait
//
// one item at a time through a sequencer over three simple dual-port rams
// (degree, community, volume), each access a read cycle then a write cycle
// an edge updates both degrees, then per active lane both communities, both volumes
// and a decision, with a move two more volume updates, then one beat handed to rsp
// a read looks up one community; an edge with a node out of range is dropped
// after reset a clearing pass over MAX_THRESHOLDS*(NUM_NODES+1) entries zeroes all
// rams while req_ready stays low; csr writes are taken during it
// a full rsp register stalls the sequencer at the next beat, not the ram work before it
module streaming_edge_community_clustering #(
   parameter int NUM_NODES      = secc_pkg::NUM_NODES_DEF,
   parameter int MAX_THRESHOLDS = secc_pkg::MAX_THRESHOLDS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [secc_pkg::NODE_W-1:0]         req_source_node,
   input  logic [secc_pkg::NODE_W-1:0]         req_target_node,
   input  logic [secc_pkg::QLANE_W-1:0]        req_query_lane,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [secc_pkg::QLANE_W-1:0]        rsp_lane,
   output logic [secc_pkg::COMM_W-1:0]         rsp_source_community,
   output logic [secc_pkg::COMM_W-1:0]         rsp_target_community,
   output logic [secc_pkg::MOVE_W-1:0]         rsp_move_kind,
   output logic                                rsp_last,
   // configuration
   input  logic                                csr_we,
   input  logic [secc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [secc_pkg::VOL_W-1:0]          csr_wdata
);

   localparam int DDEPTH = NUM_NODES;
   localparam int CDEPTH = MAX_THRESHOLDS * NUM_NODES;
   localparam int VDEPTH = MAX_THRESHOLDS * (NUM_NODES + 1);
   localparam int DAW = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
   localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
   localparam int VAW = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
   localparam int LW  = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
   localparam int CW  = secc_pkg::COMM_W;
   localparam int VW  = secc_pkg::VOL_W;

   typedef enum logic [21:0] {
      ST_CLR   = 22'd1 << 0,
      ST_IDLE  = 22'd1 << 1,
      ST_QRD   = 22'd1 << 2,
      ST_QWR   = 22'd1 << 3,
      ST_DS_RD = 22'd1 << 4,
      ST_DS_WR = 22'd1 << 5,
      ST_DT_RD = 22'd1 << 6,
      ST_DT_WR = 22'd1 << 7,
      ST_CS_RD = 22'd1 << 8,
      ST_CS_WR = 22'd1 << 9,
      ST_CT_RD = 22'd1 << 10,
      ST_CT_WR = 22'd1 << 11,
      ST_VS_RD = 22'd1 << 12,
      ST_VS_WR = 22'd1 << 13,
      ST_VT_RD = 22'd1 << 14,
      ST_VT_WR = 22'd1 << 15,
      ST_DEC   = 22'd1 << 16,
      ST_M1_RD = 22'd1 << 17,
      ST_M1_WR = 22'd1 << 18,
      ST_M2_RD = 22'd1 << 19,
      ST_M2_WR = 22'd1 << 20,
      ST_EMIT  = 22'd1 << 21
   } state_type;

   // address helpers, 32 bit intermediates then trimmed
   function automatic logic [CAW-1:0] comm_addr(input logic [31:0] lane,
                                                input logic [31:0] node);
      logic [31:0] a;
      a = lane * 32'(NUM_NODES) + node;
      return a[CAW-1:0];
   endfunction

   function automatic logic [VAW-1:0] vol_addr(input logic [31:0] lane,
                                               input logic [CW-1:0] comm);
      logic [31:0] c;
      logic [31:0] a;
      c = 32'(comm);
      if (c > 32'(NUM_NODES)) begin
         c = 32'(NUM_NODES);
      end
      a = lane * 32'(NUM_NODES + 1) + c;
      return a[VAW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [VAW-1:0] clr_ff, clr_in;

   logic [VW-1:0] vstart_ff, vend_ff;
   logic          mcond_ff;

   logic [secc_pkg::NODE_W-1:0]  src_ff, src_in, tgt_ff, tgt_in;
   logic [secc_pkg::QLANE_W-1:0] qlane_ff, qlane_in;
   logic          rd_mode_ff, rd_mode_in;
   logic [LW-1:0] lane_ff, lane_in;
   logic [LW:0]   lanes_ff, lanes_in;
   logic [CW-1:0] cs_ff, cs_in, ct_ff, ct_in;
   logic [VW-1:0] vs_ff, vs_in, vt_ff, vt_in;
   logic [VW-1:0] dsrc_ff, dsrc_in, dtgt_ff, dtgt_in;
   logic [secc_pkg::MOVE_W-1:0] mv_ff, mv_in;
   logic [CW-1:0] nid_ff [MAX_THRESHOLDS];
   logic [CW-1:0] nid_in [MAX_THRESHOLDS];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [secc_pkg::QLANE_W-1:0] rsp_lane_ff, rsp_lane_in;
   logic [CW-1:0]                rsp_sc_ff, rsp_sc_in, rsp_tc_ff, rsp_tc_in;
   logic [secc_pkg::MOVE_W-1:0]  rsp_mv_ff, rsp_mv_in;
   logic                         rsp_last_ff, rsp_last_in;

   // ram ports
   logic           deg_we, comm_we, vol_we;
   logic [DAW-1:0] deg_waddr, deg_raddr;
   logic [CAW-1:0] comm_waddr, comm_raddr;
   logic [VAW-1:0] vol_waddr, vol_raddr;
   logic [VW-1:0]  deg_wdata, deg_rdata, vol_wdata, vol_rdata;
   logic [CW-1:0]  comm_wdata, comm_rdata;

   secc_ram #(.WIDTH(VW), .DEPTH(DDEPTH)) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_waddr),
      .wr_data (deg_wdata),
      .rd_addr (deg_raddr),
      .rd_data (deg_rdata)
   );

   secc_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_comm_ram (
      .clock   (clock),
      .wr_en   (comm_we),
      .wr_addr (comm_waddr),
      .wr_data (comm_wdata),
      .rd_addr (comm_raddr),
      .rd_data (comm_rdata)
   );

   secc_ram #(.WIDTH(VW), .DEPTH(VDEPTH)) u_vol_ram (
      .clock   (clock),
      .wr_en   (vol_we),
      .wr_addr (vol_waddr),
      .wr_data (vol_wdata),
      .rd_addr (vol_raddr),
      .rd_data (vol_rdata)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vstart_ff <= VW'(9);
         vend_ff   <= VW'(9);
         mcond_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            secc_pkg::REG_VMAX_START:      vstart_ff <= csr_wdata;
            secc_pkg::REG_VMAX_END:        vend_ff   <= csr_wdata;
            secc_pkg::REG_MERGE_CONDITION: mcond_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [31:0] lane32, src32, tgt32, qlane32, clr32;
   logic        req_take, rsp_free, mover_src, last_lane, merge_ok;
   logic [VW:0] diff, limit;
   logic [VW-1:0] md, inc_val;
   logic [CW-1:0] from_c, to_c;

   assign lane32  = 32'(lane_ff);
   assign src32   = 32'(src_ff);
   assign tgt32   = 32'(tgt_ff);
   assign qlane32 = 32'(qlane_ff);
   assign clr32   = 32'(clr_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // mover is source when its volume is strictly smaller
   assign mover_src = (vs_ff < vt_ff);
   assign md        = mover_src ? dsrc_ff : dtgt_ff;
   assign from_c    = mover_src ? cs_ff : ct_ff;
   assign to_c      = mover_src ? ct_ff : cs_ff;
   assign last_lane = ((LW+1)'(lane_ff) + (LW+1)'(1)) == lanes_ff;

   assign diff  = {1'b0, vend_ff} - {1'b0, vstart_ff};
   assign limit = {1'b0, vstart_ff} + (VW+1)'(lane_ff);
   assign merge_ok = mcond_ff ? (({1'b0, vs_ff} <= limit) || ({1'b0, vt_ff} <= limit))
                              : (({1'b0, vs_ff} <= limit) && ({1'b0, vt_ff} <= limit));
   assign inc_val = secc_pkg::sat_add(vol_rdata, VW'(1));

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      src_in     = src_ff;
      tgt_in     = tgt_ff;
      qlane_in   = qlane_ff;
      rd_mode_in = rd_mode_ff;
      lane_in    = lane_ff;
      lanes_in   = lanes_ff;
      cs_in      = cs_ff;
      ct_in      = ct_ff;
      vs_in      = vs_ff;
      vt_in      = vt_ff;
      dsrc_in    = dsrc_ff;
      dtgt_in    = dtgt_ff;
      mv_in      = mv_ff;
      nid_in     = nid_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_lane_in  = rsp_lane_ff;
      rsp_sc_in    = rsp_sc_ff;
      rsp_tc_in    = rsp_tc_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_last_in  = rsp_last_ff;

      deg_we     = 1'b0;
      deg_waddr  = src32[DAW-1:0];
      deg_wdata  = '0;
      deg_raddr  = src32[DAW-1:0];
      comm_we    = 1'b0;
      comm_waddr = comm_addr(lane32, src32);
      comm_wdata = '0;
      comm_raddr = comm_addr(lane32, src32);
      vol_we     = 1'b0;
      vol_waddr  = vol_addr(lane32, cs_ff);
      vol_wdata  = '0;
      vol_raddr  = vol_addr(lane32, cs_ff);

      case (state_ff)
         ST_CLR: begin
            // zero every ram, one entry per cycle
            deg_we     = clr32 < 32'(DDEPTH);
            deg_waddr  = clr32[DAW-1:0];
            comm_we    = clr32 < 32'(CDEPTH);
            comm_waddr = clr32[CAW-1:0];
            vol_we     = 1'b1;
            vol_waddr  = clr_ff;
            clr_in     = clr_ff + VAW'(1);
            if (clr32 == 32'(VDEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               src_in   = req_source_node;
               tgt_in   = req_target_node;
               qlane_in = req_query_lane;
               cs_in    = '0;
               ct_in    = '0;
               mv_in    = secc_pkg::MOVE_NONE;
               if (vend_ff < vstart_ff) begin
                  lanes_in = '0;
               end else if (diff >= (VW+1)'(MAX_THRESHOLDS)) begin
                  lanes_in = (LW+1)'(MAX_THRESHOLDS);
               end else begin
                  lanes_in = (LW+1)'(diff) + (LW+1)'(1);
               end
               if (req_func == secc_pkg::FUNC_READ) begin
                  rd_mode_in = 1'b1;
                  if ((32'(req_query_lane) < 32'(MAX_THRESHOLDS)) &&
                      (32'(req_source_node) < 32'(NUM_NODES))) begin
                     state_in = ST_QRD;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  rd_mode_in = 1'b0;
                  // out of range edges are dropped
                  if ((32'(req_source_node) < 32'(NUM_NODES)) &&
                      (32'(req_target_node) < 32'(NUM_NODES))) begin
                     state_in = ST_DS_RD;
                  end
               end
            end
         end
         ST_QRD: begin
            comm_raddr = comm_addr(qlane32, src32);
            state_in   = ST_QWR;
         end
         ST_QWR: begin
            cs_in    = comm_rdata;
            state_in = ST_EMIT;
         end
         ST_DS_RD: begin
            deg_raddr = src32[DAW-1:0];
            state_in  = ST_DS_WR;
         end
         ST_DS_WR: begin
            deg_we    = 1'b1;
            deg_waddr = src32[DAW-1:0];
            deg_wdata = secc_pkg::sat_add(deg_rdata, VW'(1));
            dsrc_in   = deg_wdata;
            state_in  = ST_DT_RD;
         end
         ST_DT_RD: begin
            deg_raddr = tgt32[DAW-1:0];
            state_in  = ST_DT_WR;
         end
         ST_DT_WR: begin
            deg_we    = 1'b1;
            deg_waddr = tgt32[DAW-1:0];
            deg_wdata = secc_pkg::sat_add(deg_rdata, VW'(1));
            dtgt_in   = deg_wdata;
            // self loop: source degree is the final one
            if (src_ff == tgt_ff) begin
               dsrc_in = deg_wdata;
            end
            lane_in = '0;
            if (lanes_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CS_RD;
            end
         end
         ST_CS_RD: begin
            comm_raddr = comm_addr(lane32, src32);
            state_in   = ST_CS_WR;
         end
         ST_CS_WR: begin
            comm_waddr = comm_addr(lane32, src32);
            if (comm_rdata == '0) begin
               comm_we         = 1'b1;
               comm_wdata      = nid_ff[lane_ff];
               cs_in           = nid_ff[lane_ff];
               nid_in[lane_ff] = nid_ff[lane_ff] + CW'(1);
            end else begin
               cs_in = comm_rdata;
            end
            state_in = ST_CT_RD;
         end
         ST_CT_RD: begin
            comm_raddr = comm_addr(lane32, tgt32);
            state_in   = ST_CT_WR;
         end
         ST_CT_WR: begin
            comm_waddr = comm_addr(lane32, tgt32);
            if (comm_rdata == '0) begin
               comm_we         = 1'b1;
               comm_wdata      = nid_ff[lane_ff];
               ct_in           = nid_ff[lane_ff];
               nid_in[lane_ff] = nid_ff[lane_ff] + CW'(1);
            end else begin
               ct_in = comm_rdata;
            end
            state_in = ST_VS_RD;
         end
         ST_VS_RD: begin
            vol_raddr = vol_addr(lane32, cs_ff);
            state_in  = ST_VS_WR;
         end
         ST_VS_WR: begin
            vol_we    = 1'b1;
            vol_waddr = vol_addr(lane32, cs_ff);
            vol_wdata = inc_val;
            vs_in     = inc_val;
            state_in  = ST_VT_RD;
         end
         ST_VT_RD: begin
            vol_raddr = vol_addr(lane32, ct_ff);
            state_in  = ST_VT_WR;
         end
         ST_VT_WR: begin
            vol_we    = 1'b1;
            vol_waddr = vol_addr(lane32, ct_ff);
            vol_wdata = inc_val;
            vt_in     = inc_val;
            state_in  = ST_DEC;
         end
         ST_DEC: begin
            if (merge_ok) begin
               mv_in    = mover_src ? secc_pkg::MOVE_SRC : secc_pkg::MOVE_TGT;
               state_in = ST_M1_RD;
            end else begin
               mv_in    = secc_pkg::MOVE_NONE;
               state_in = ST_EMIT;
            end
         end
         ST_M1_RD: begin
            vol_raddr = vol_addr(lane32, from_c);
            state_in  = ST_M1_WR;
         end
         ST_M1_WR: begin
            vol_we    = 1'b1;
            vol_waddr = vol_addr(lane32, from_c);
            vol_wdata = secc_pkg::sat_sub(vol_rdata, md);
            state_in  = ST_M2_RD;
         end
         ST_M2_RD: begin
            vol_raddr = vol_addr(lane32, to_c);
            state_in  = ST_M2_WR;
         end
         ST_M2_WR: begin
            // add the degree to the new community and relabel the mover
            vol_we     = 1'b1;
            vol_waddr  = vol_addr(lane32, to_c);
            vol_wdata  = secc_pkg::sat_add(vol_rdata, md);
            comm_we    = 1'b1;
            comm_waddr = comm_addr(lane32, mover_src ? src32 : tgt32);
            comm_wdata = to_c;
            if (mover_src) begin
               cs_in = ct_ff;
            end else begin
               ct_in = cs_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sc_in    = cs_ff;
               rsp_tc_in    = ct_ff;
               rsp_mv_in    = mv_ff;
               if (rd_mode_ff) begin
                  rsp_lane_in = qlane_ff;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_lane_in = lane32[secc_pkg::QLANE_W-1:0];
                  rsp_last_in = last_lane;
                  if (last_lane) begin
                     state_in = ST_IDLE;
                  end else begin
                     lane_in  = lane_ff + LW'(1);
                     state_in = ST_CS_RD;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_THRESHOLDS; i++) begin
            nid_ff[i] <= CW'(1);
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         nid_ff       <= nid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      tgt_ff      <= tgt_in;
      qlane_ff    <= qlane_in;
      rd_mode_ff  <= rd_mode_in;
      lane_ff     <= lane_in;
      lanes_ff    <= lanes_in;
      cs_ff       <= cs_in;
      ct_ff       <= ct_in;
      vs_ff       <= vs_in;
      vt_ff       <= vt_in;
      dsrc_ff     <= dsrc_in;
      dtgt_ff     <= dtgt_in;
      mv_ff       <= mv_in;
      rsp_lane_ff <= rsp_lane_in;
      rsp_sc_ff   <= rsp_sc_in;
      rsp_tc_ff   <= rsp_tc_in;
      rsp_mv_ff   <= rsp_mv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_lane             = rsp_lane_ff;
   assign rsp_source_community = rsp_sc_ff;
   assign rsp_target_community = rsp_tc_ff;
   assign rsp_move_kind        = rsp_mv_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// ===== src/secc_ram.sv =====
module secc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
